/* rtl/rational_reduce_macros.svh */
// ----------------------------------------------------------------------------
// rational_reduce_macros.svh
// Assertion macros used by the checker file of the fraction reducer.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_REDUCE_MACROS_SVH
`define RATIONAL_REDUCE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define RR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define RR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rr_pkg.sv */
// ----------------------------------------------------------------------------
// rr_pkg
// Widths, sequencer states and divider request types of the fraction reducer.
// ----------------------------------------------------------------------------
package rr_pkg;

  // Width of the signed input fields
  localparam int DATA_WIDTH = 32;
  // Step counter of the divider: one quotient bit per cycle
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_CHECK,
    ST_GCD_START,
    ST_GCD_WAIT,
    ST_QN_START,
    ST_QN_WAIT,
    ST_QD_START,
    ST_QD_WAIT,
    ST_FINISH
  } state_e;

  // Request to the shared divider
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  // Answer of the shared divider, valid in the cycle done is high
  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_rsp_t;

endpackage

/* rtl/rr_divider.sv */
// ----------------------------------------------------------------------------
// rr_divider
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// remainder steps of Euclid's loop and the two final divisions.
// ----------------------------------------------------------------------------
module rr_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rr_pkg::div_req_t req_i,
  output rr_pkg::div_rsp_t rsp_o
);
  import rr_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  word_t            rem_q, rem_d;
  word_t            quo_q, quo_d;
  word_t            dsr_q, dsr_d;

  logic [DATA_WIDTH:0] shifted;
  logic [DATA_WIDTH:0] diff;
  logic                fits;

  // Trial subtraction of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem_q, quo_q[DATA_WIDTH-1]};
    diff    = shifted - {1'b0, dsr_q};
    fits    = shifted >= {1'b0, dsr_q};
  end

  // Load on start, then advance one bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_d = {quo_q[DATA_WIDTH-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers hold without reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* rtl/rational_reduce.sv */
// ----------------------------------------------------------------------------
// rational_reduce
// Reduces a signed fraction to lowest terms with a non-negative denominator.
// ----------------------------------------------------------------------------
// One request at a time. A zero numerator gives 0/1 without using the divider.
// Otherwise the single bit-serial divider serves every remainder step of
// Euclid's loop (at most about 46 at 32 bits) and both final divisions.
// in_stall_o is high from acceptance until the result moves into the output
// register; a finished result waits there for the consumer while the next
// request is taken. A zero denominator with a nonzero numerator gives +1/0 or
// -1/0.
module rational_reduce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [rr_pkg::DATA_WIDTH-1:0] numerator_in_i,
  input  logic signed [rr_pkg::DATA_WIDTH-1:0] denominator_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [rr_pkg::DATA_WIDTH-1:0] reduced_numerator_o,
  output logic        [rr_pkg::DATA_WIDTH-2:0] reduced_denominator_o
);
  import rr_pkg::*;

  state_e   state_q, state_d;
  div_req_t div_req;
  div_rsp_t div_rsp;

  word_t a_q, a_d;
  word_t b_q, b_d;
  word_t nmag_q, nmag_d;
  word_t dmag_q, dmag_d;
  word_t qn_q, qn_d;
  word_t qd_q, qd_d;
  logic  neg_q, neg_d;

  logic                    out_valid_q, out_valid_d;
  word_t                   out_num_q, out_num_d;
  logic [DATA_WIDTH-2:0]   out_den_q, out_den_d;

  logic  accept;
  logic  slot_free;
  word_t nmag_in;
  word_t dmag_in;

  assign accept    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;

  // Magnitudes of the incoming parts
  always_comb begin
    nmag_in = numerator_in_i[DATA_WIDTH-1]   ? word_t'(-numerator_in_i)   : numerator_in_i;
    dmag_in = denominator_in_i[DATA_WIDTH-1] ? word_t'(-denominator_in_i) : denominator_in_i;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (nmag_in == '0) ? ST_FINISH : ST_GCD_CHECK;
        end
      end
      ST_GCD_CHECK: state_d = (b_q == '0) ? ST_QN_START : ST_GCD_START;
      ST_GCD_START: state_d = ST_GCD_WAIT;
      ST_GCD_WAIT:  if (div_rsp.done) state_d = ST_GCD_CHECK;
      ST_QN_START:  state_d = ST_QN_WAIT;
      ST_QN_WAIT:   if (div_rsp.done) state_d = ST_QD_START;
      ST_QD_START:  state_d = ST_QD_WAIT;
      ST_QD_WAIT:   if (div_rsp.done) state_d = ST_FINISH;
      ST_FINISH:    if (slot_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: stall and divider operands
  always_comb begin
    in_stall_o       = 1'b1;
    div_req.start    = 1'b0;
    div_req.dividend = a_q;
    div_req.divisor  = b_q;
    unique case (state_q)
      ST_IDLE:      in_stall_o = 1'b0;
      ST_GCD_START: div_req.start = 1'b1;
      ST_QN_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = nmag_q;
        div_req.divisor  = a_q;
      end
      ST_QD_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = dmag_q;
        div_req.divisor  = a_q;
      end
      default: ;
    endcase
  end

  // Datapath updates
  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    nmag_d      = nmag_q;
    dmag_d      = dmag_q;
    qn_d        = qn_q;
    qd_d        = qd_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_num_d   = out_num_q;
    out_den_d   = out_den_q;
    if (accept) begin
      a_d    = nmag_in;
      b_d    = dmag_in;
      nmag_d = nmag_in;
      dmag_d = dmag_in;
      neg_d  = numerator_in_i[DATA_WIDTH-1] ^ denominator_in_i[DATA_WIDTH-1];
      qn_d   = '0;
      qd_d   = word_t'(1);
    end
    if (div_rsp.done) begin
      unique case (state_q)
        ST_GCD_WAIT: begin
          a_d = b_q;
          b_d = div_rsp.remainder;
        end
        ST_QN_WAIT: qn_d = div_rsp.quotient;
        ST_QD_WAIT: qd_d = div_rsp.quotient;
        default: ;
      endcase
    end
    // Move the finished result into the output register
    if (state_q == ST_FINISH && slot_free) begin
      out_valid_d = 1'b1;
      out_num_d   = neg_q ? word_t'(-qn_q) : qn_q;
      out_den_d   = qd_q[DATA_WIDTH-2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    nmag_q    <= nmag_d;
    dmag_q    <= dmag_d;
    qn_q      <= qn_d;
    qd_q      <= qd_d;
    neg_q     <= neg_d;
    out_num_q <= out_num_d;
    out_den_q <= out_den_d;
  end

  rr_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o           = out_valid_q;
  assign reduced_numerator_o   = out_num_q;
  assign reduced_denominator_o = out_den_q;

endmodule

/* rtl/rr_checker.sv */
// ----------------------------------------------------------------------------
// rr_checker
// Port-level checks of the fraction reducer, bound to the top level.
// ----------------------------------------------------------------------------
`include "rational_reduce_macros.svh"

module rr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [rr_pkg::DATA_WIDTH-1:0] numerator_in_i,
  input logic [rr_pkg::DATA_WIDTH-1:0] denominator_in_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rr_pkg::DATA_WIDTH-1:0] reduced_numerator_o,
  input logic [rr_pkg::DATA_WIDTH-2:0] reduced_denominator_o
);
  import rr_pkg::*;

  // An accepted request keeps the block busy in the next cycle
  `RR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")

  // A stalled request holds its payload
  `RR_ASSERT_NEXT(a_req_hold, in_valid_i && in_stall_o, in_valid_i && $stable(numerator_in_i) && $stable(denominator_in_i), "stalled request changed")

  // A stalled result holds its value
  `RR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(reduced_numerator_o) && $stable(reduced_denominator_o), "stalled result changed")

  // A zero numerator always comes with a unit denominator
  `RR_ASSERT(a_zero_over_one, out_valid_o && reduced_numerator_o == '0, reduced_denominator_o == (DATA_WIDTH-1)'(1), "zero numerator without unit denominator")

  // A fresh result appears only out of a busy cycle
  `RR_ASSERT(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o), "result without work")

endmodule

bind rational_reduce rr_checker u_rr_checker (.*);

/* tb/tb_rational_reduce.sv */
// ----------------------------------------------------------------------------
// tb_rational_reduce
// Self-checking bench for the fraction reducer: directed and random fractions
// go in through a bursty request driver, and a monitor with its own stall
// pattern checks every reduced fraction against a behavioural reduction.
// ----------------------------------------------------------------------------
module tb_rational_reduce;

  import rr_pkg::*;

  localparam int    W        = DATA_WIDTH;
  localparam word_t MAX_POS  = {1'b0, {(W-1){1'b1}}};
  localparam word_t MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam int    N_RANDOM = 700;
  localparam int    HOLD_LEN = 6000;

  // A fraction request and the reduced fraction it should produce
  typedef struct {
    word_t                num;
    word_t                den;
    logic signed [W-1:0]  red_num;
    logic        [W-2:0]  red_den;
  } fraction_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_stall_o;
  logic signed [W-1:0]  numerator_in_i   = '0;
  logic signed [W-1:0]  denominator_in_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i      = 1'b0;
  logic signed [W-1:0]  reduced_numerator_o;
  logic        [W-2:0]  reduced_denominator_o;

  fraction_t request_q[$];
  fraction_t awaited_fractions[$];
  fraction_t next_req;
  fraction_t got_exp;
  word_t     fib[0:46];

  int        total_requests;
  int        accepted_cnt;
  int        results_seen;
  int        errors;
  int        burst_left;
  int        gap_left;
  int        rx_left;
  int        hold_left;
  logic      hold_done;
  logic      stall_next;
  rx_mode_e  rx_mode;

  rational_reduce u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .numerator_in_i        (numerator_in_i),
    .denominator_in_i      (denominator_in_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .reduced_numerator_o   (reduced_numerator_o),
    .reduced_denominator_o (reduced_denominator_o)
  );

  // Clock, period 4
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Reduce n/d by Euclid's remainder loop; sign goes on the numerator
  function automatic fraction_t reduce_fraction(word_t n, word_t d);
    fraction_t res;
    word_t     nmag, dmag, a, b, r, qn, qd;
    logic      nneg, dneg;
    res.num = n;
    res.den = d;
    nneg = n[W-1];
    dneg = d[W-1];
    nmag = nneg ? word_t'(-n) : n;
    dmag = dneg ? word_t'(-d) : d;
    if (nmag == '0) begin
      res.red_num = '0;
      res.red_den = (W-1)'(1);
      return res;
    end
    a = nmag;
    b = dmag;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    qn = nmag / a;
    qd = dmag / a;
    res.red_num = (nneg != dneg) ? word_t'(-qn) : qn;
    res.red_den = qd[W-2:0];
    return res;
  endfunction

  task automatic push_req(word_t n, word_t d);
    fraction_t f;
    f.num = n;
    f.den = d;
    request_q.push_back(f);
  endtask

  // Any value in range, the most negative one excluded
  function automatic word_t rand_word();
    word_t v;
    v = $urandom;
    if (v == MOST_NEG) v = v + 1;
    return v;
  endfunction

  function automatic word_t rand_sign(word_t v);
    return $urandom_range(0, 1) ? word_t'(-v) : v;
  endfunction

  // Random fraction from a mix of shapes that stress different paths
  task automatic push_random();
    int    pick, k;
    word_t g, a, b;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      push_req(rand_word(), rand_word());
    end else if (pick < 48) begin
      push_req(word_t'($urandom_range(0, 200)) - 100, word_t'($urandom_range(0, 200)) - 100);
    end else if (pick < 63) begin
      g = $urandom_range(1, 65535);
      a = $urandom_range(0, 32767);
      b = $urandom_range(0, 32767);
      push_req(rand_sign(a * g), rand_sign(b * g));
    end else if (pick < 70) begin
      push_req('0, rand_word());
    end else if (pick < 77) begin
      push_req(rand_word(), '0);
    end else if (pick < 84) begin
      // consecutive Fibonacci numbers give the longest remainder chains
      k = $urandom_range(2, 46);
      push_req(rand_sign(fib[k]), rand_sign(fib[k-1]));
    end else if (pick < 92) begin
      a = word_t'(1) << $urandom_range(0, W - 2);
      b = word_t'(1) << $urandom_range(0, W - 2);
      push_req(rand_sign(a), rand_sign(b));
    end else begin
      // one part a multiple of the other
      a = $urandom_range(1, 1 << 20);
      b = a * $urandom_range(1, 2047);
      if ($urandom_range(0, 1)) push_req(rand_sign(a), rand_sign(b));
      else push_req(rand_sign(b), rand_sign(a));
    end
  endtask

  // Request driver: bursts of random length, random gaps, payload held while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      numerator_in_i   <= '0;
      denominator_in_i <= '0;
      burst_left       <= 1;
      gap_left         <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        awaited_fractions.push_back(reduce_fraction(numerator_in_i, denominator_in_i));
        accepted_cnt++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (request_q.size() != 0) begin
          next_req          = request_q.pop_front();
          numerator_in_i   <= next_req.num;
          denominator_in_i <= next_req.den;
          in_valid_i       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the consumer, once, so the reducer backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen == 150) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: check against the oldest awaited fraction, stall on its own pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      rx_mode      <= RX_FREE;
      rx_left      <= 100;
      results_seen <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (awaited_fractions.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %0d/%0d", $time,
                   reduced_numerator_o, reduced_denominator_o);
        end else begin
          got_exp = awaited_fractions.pop_front();
          if (reduced_numerator_o !== got_exp.red_num) begin
            errors++;
            $display("%0t: %0d/%0d numerator expected %0d actual %0d", $time,
                     $signed(got_exp.num), $signed(got_exp.den),
                     got_exp.red_num, reduced_numerator_o);
          end
          if (reduced_denominator_o !== got_exp.red_den) begin
            errors++;
            $display("%0t: %0d/%0d denominator expected %0d actual %0d", $time,
                     $signed(got_exp.num), $signed(got_exp.den),
                     got_exp.red_den, reduced_denominator_o);
          end
        end
      end
      // switch stall pattern now and then
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 400);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FREE:  stall_next = 1'b0;
        RX_LIGHT: stall_next = ($urandom_range(0, 99) < 30);
        RX_HEAVY: stall_next = ($urandom_range(0, 99) < 80);
        default:  stall_next = !out_stall_i;
      endcase
      out_stall_i <= (hold_left != 0) || stall_next;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    errors       = 0;
    accepted_cnt = 0;
    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i <= 46; i++) fib[i] = fib[i-1] + fib[i-2];

    // zero numerator, whatever the denominator
    push_req(0, 5);
    push_req(0, 0);
    push_req(0, -7);
    push_req(0, MAX_POS);
    // zero denominator keeps only the sign
    push_req(5, 0);
    push_req(-5, 0);
    push_req(MAX_POS, 0);
    // all sign combinations
    push_req(6, 4);
    push_req(-6, 4);
    push_req(6, -4);
    push_req(-6, -4);
    push_req(12, 18);
    push_req(1, 1);
    push_req(-1, -1);
    push_req(1, -1);
    push_req(7, 7);
    // extremes of the range
    push_req(MAX_POS, MAX_POS);
    push_req(-MAX_POS, MAX_POS);
    push_req(MAX_POS, -MAX_POS);
    push_req(MAX_POS, 1);
    push_req(1, -MAX_POS);
    push_req(-MAX_POS, -1);
    push_req(32'h4000_0000, 32'h0010_0000);
    // longest remainder chain
    push_req(fib[46], fib[45]);
    push_req(-fib[45], fib[46]);

    for (int i = 0; i < N_RANDOM; i++) push_random();
    total_requests = request_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt != total_requests) @(posedge clk_i);
    while (awaited_fractions.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Give up on a hang
  initial begin
    #24000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/rr_pkg.sv
rtl/rr_divider.sv
rtl/rational_reduce.sv
rtl/rr_checker.sv
tb/tb_rational_reduce.sv
